/* design/kes_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// kes_pkg
// Shared sizes, codes, types and tables of the key and encoder event scanner.
// ----------------------------------------------------------------------------
package kes_pkg;

  // Matrix, switches and slot store
  localparam int KEY_COUNT    = 16;
  localparam int MATRIX_COLS  = 4;
  localparam int SWITCH_COUNT = 2;
  localparam int SLOT_COUNT   = KEY_COUNT + SWITCH_COUNT;
  localparam int SLOT_W       = $clog2(SLOT_COUNT);

  // Event queue
  localparam int FIFO_DEPTH = 32;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  // Field widths
  localparam int STAMP_W   = 32;
  localparam int KIND_W    = 2;
  localparam int ID_W      = 8;
  localparam int AB_W      = 2;
  localparam int ACC_W     = 4;
  localparam int DEBOUNCE_W = 20;
  localparam int DETENT_W  = 3;
  localparam int UNUSED_W  = 5;
  localparam int CFG_W     = 20;
  localparam int CFG_IDX_W = 3;

  // Register reset values
  localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RESET = DEBOUNCE_W'(15000);
  localparam logic [DETENT_W-1:0]   DETENT_RESET   = DETENT_W'(4);
  localparam logic [UNUSED_W-1:0]   UNUSED_RESET   = UNUSED_W'(15);
  localparam logic [ID_W-1:0]       SWITCH0_RESET  = ID_W'(16);
  localparam logic [ID_W-1:0]       SWITCH1_RESET  = ID_W'(17);
  localparam logic [ID_W-1:0]       ENCODER0_RESET = ID_W'(18);
  localparam logic [ID_W-1:0]       ENCODER1_RESET = ID_W'(19);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DEBOUNCE = 3'd0,
    CFG_DETENT   = 3'd1,
    CFG_UNUSED   = 3'd2,
    CFG_SWITCH0  = 3'd3,
    CFG_SWITCH1  = 3'd4,
    CFG_ENCODER0 = 3'd5,
    CFG_ENCODER1 = 3'd6
  } cfg_index_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_PRESS   = 2'd0,
    KIND_RELEASE = 2'd1,
    KIND_CW      = 2'd2,
    KIND_CCW     = 2'd3
  } event_kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_ENC0,
    ST_ENC1,
    ST_POP_RD,
    ST_POP_OUT
  } scan_state_t;

  // One queued event
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [ID_W-1:0]   id;
  } event_entry_t;

  // Push request into the event queue
  typedef struct packed {
    logic              valid;
    logic [KIND_W-1:0] kind;
    logic [ID_W-1:0]   id;
  } push_req_t;

  // Slot store entry and write port
  typedef struct packed {
    logic               level;
    logic [STAMP_W-1:0] stamp;
  } slot_entry_t;

  typedef struct packed {
    logic              en;
    logic [SLOT_W-1:0] addr;
    slot_entry_t       entry;
  } slot_wr_t;

  // Encoder step command
  typedef struct packed {
    logic            en;
    logic            sel;
    logic [AB_W-1:0] ab;
  } enc_step_t;

  // Column-major visit order of the keys, then the switches
  typedef logic [SLOT_W-1:0] visit_tab_t [SLOT_COUNT];

  function automatic visit_tab_t build_visit();
    visit_tab_t tab;
    int n;
    n = 0;
    for (int c = 0; c < MATRIX_COLS; c++) begin
      for (int r = 0; r * MATRIX_COLS + c < KEY_COUNT; r++) begin
        tab[n] = SLOT_W'(r * MATRIX_COLS + c);
        n++;
      end
    end
    for (int s = KEY_COUNT; s < SLOT_COUNT; s++) begin
      tab[s] = SLOT_W'(s);
    end
    return tab;
  endfunction

  localparam visit_tab_t VISIT_ORDER = build_visit();

  // Gray transition step: +1, -1, or 0 for no move or a double jump
  function automatic logic signed [1:0] gray_step(input logic [AB_W-1:0] prev,
                                                  input logic [AB_W-1:0] cur);
    logic signed [1:0] s;
    case ({prev, cur})
      4'b0001: s = 2'sb11;
      4'b0010: s = 2'sb01;
      4'b0100: s = 2'sb01;
      4'b0111: s = 2'sb11;
      4'b1000: s = 2'sb11;
      4'b1011: s = 2'sb01;
      4'b1101: s = 2'sb01;
      4'b1110: s = 2'sb11;
      default: s = 2'sb00;
    endcase
    return s;
  endfunction

  // Queue pointer advance with wrap at the depth
  function automatic logic [FIFO_AW-1:0] ptr_inc(input logic [FIFO_AW-1:0] p);
    return (p == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : p + FIFO_AW'(1);
  endfunction

endpackage
`default_nettype wire

/* design/kes_slot_store.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// kes_slot_store
// Level and last-change stamp of every key and push switch, one entry per
// slot, registered read. Valid bits make unwritten slots read as
// released with a zero stamp.
// ----------------------------------------------------------------------------
module kes_slot_store (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      rd_en,
  input  wire logic [kes_pkg::SLOT_W-1:0] rd_addr,
  output      kes_pkg::slot_entry_t      rd_data,
  input  wire kes_pkg::slot_wr_t         wr
);
  import kes_pkg::*;

  slot_entry_t           mem [SLOT_COUNT];
  logic [SLOT_COUNT-1:0] valid;
  slot_entry_t           rd_q;
  logic                  rd_valid;

  // Storage array and read register
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.entry;
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  // Written-slot flags
  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= '0;
      rd_valid <= 1'b0;
    end else begin
      if (wr.en) begin
        valid[wr.addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_valid <= valid[rd_addr];
      end
    end
  end

  assign rd_data = rd_valid ? rd_q : '0;

endmodule
`default_nettype wire

/* design/kes_event_fifo.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// kes_event_fifo
// Circular event queue holding up to FIFO_DEPTH-1 events; a push into a full
// queue is dropped. Pop reads the head entry into a register.
// ----------------------------------------------------------------------------
module kes_event_fifo (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire kes_pkg::push_req_t    push,
  input  wire logic                  pop,
  output      kes_pkg::event_entry_t rd_data,
  output      logic                  empty
);
  import kes_pkg::*;

  event_entry_t       mem [FIFO_DEPTH];
  event_entry_t       rd_q;
  logic [FIFO_AW-1:0] head;
  logic [FIFO_AW-1:0] tail;
  logic               full;
  logic               do_push;

  assign full    = (ptr_inc(tail) == head);
  assign empty   = (head == tail);
  assign do_push = push.valid && !full;

  // Storage and head read
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[tail] <= '{kind: push.kind, id: push.id};
    end
    if (pop) begin
      rd_q <= mem[head];
    end
  end

  // Pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      tail <= '0;
    end else begin
      if (do_push) begin
        tail <= ptr_inc(tail);
      end
      if (pop) begin
        head <= ptr_inc(head);
      end
    end
  end

  assign rd_data = rd_q;

endmodule
`default_nettype wire

/* design/kes_encoder.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// kes_encoder
// Quadrature state of both encoders. Each step command advances one encoder
// through the Gray table and raises a click event at plus or minus detent.
// ----------------------------------------------------------------------------
module kes_encoder (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire kes_pkg::enc_step_t           step,
  input  wire logic [kes_pkg::DETENT_W-1:0] detent_count,
  input  wire logic [kes_pkg::ID_W-1:0]     encoder0_id,
  input  wire logic [kes_pkg::ID_W-1:0]     encoder1_id,
  output      kes_pkg::push_req_t           push
);
  import kes_pkg::*;

  logic [AB_W-1:0]          prev_ab [2];
  logic signed [ACC_W-1:0]  accum [2];
  logic                     primed;

  logic [AB_W-1:0]          cur_prev;
  logic signed [ACC_W-1:0]  cur_acc;
  logic [DETENT_W-1:0]      detent_eff;
  logic signed [ACC_W:0]    detent_s;
  logic signed [ACC_W:0]    acc_sum;
  logic                     moved;
  logic                     hit_cw;
  logic                     hit_ccw;
  logic signed [ACC_W-1:0]  acc_next;

  // Step arithmetic for the selected encoder
  always_comb begin
    cur_prev   = prev_ab[step.sel];
    cur_acc    = accum[step.sel];
    detent_eff = (detent_count == '0) ? DETENT_W'(1) : detent_count;
    detent_s   = $signed((ACC_W + 1)'(detent_eff));
    acc_sum    = (ACC_W + 1)'(cur_acc) + (ACC_W + 1)'(gray_step(cur_prev, step.ab));
    moved      = primed && (step.ab != cur_prev);
    hit_cw     = acc_sum >= detent_s;
    hit_ccw    = acc_sum <= -detent_s;
    acc_next   = (hit_cw || hit_ccw) ? '0 : acc_sum[ACC_W-1:0];

    push.valid = step.en && moved && (hit_cw || hit_ccw);
    push.kind  = hit_cw ? KIND_CW : KIND_CCW;
    push.id    = step.sel ? encoder1_id : encoder0_id;
  end

  // Encoder state; the first poll only captures levels
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_ab[0] <= '0;
      prev_ab[1] <= '0;
      accum[0]   <= '0;
      accum[1]   <= '0;
      primed     <= 1'b0;
    end else if (step.en) begin
      if (!primed) begin
        prev_ab[step.sel] <= step.ab;
      end else if (moved) begin
        prev_ab[step.sel] <= step.ab;
        accum[step.sel]   <= acc_next;
      end
      if (step.sel) begin
        primed <= 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

/* design/key_encoder_event_scanner.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// key_encoder_event_scanner
// Debounced key matrix and push-switch scanner with two quadrature encoders
// and an event queue; each poll queues the events it finds and pops at most one.
//
//   channel | direction | handshake            | payload
//   poll    | in        | poll_valid/poll_stall | now_us, key_pressed,
//           |           |                       | switch_pressed, enc0_ab, enc1_ab
//   event   | out       | event_valid/event_stall | event_kind, event_id
//   cfg     | in        | cfg_write             | cfg_index, cfg_data
//
// A poll runs in order: accept, one slot store read a cycle for the 18 key
// and switch slots, the last write-back, a step for each encoder, then a
// queue read and the output load, both left out when the queue is empty.
// The slot store read port and the single queue write port set this order.
// Reset loads control state and config defaults; valid bits stand in for a clear.
// A stalled output beat holds the pop until the output register is free.
// ----------------------------------------------------------------------------
module key_encoder_event_scanner (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           poll_valid,
  output      logic                           poll_stall,
  input  wire logic [kes_pkg::STAMP_W-1:0]    now_us,
  input  wire logic [kes_pkg::KEY_COUNT-1:0]  key_pressed,
  input  wire logic [kes_pkg::SWITCH_COUNT-1:0] switch_pressed,
  input  wire logic [kes_pkg::AB_W-1:0]       enc0_ab,
  input  wire logic [kes_pkg::AB_W-1:0]       enc1_ab,
  output      logic                           event_valid,
  input  wire logic                           event_stall,
  output      logic [kes_pkg::KIND_W-1:0]     event_kind,
  output      logic [kes_pkg::ID_W-1:0]       event_id,
  input  wire logic                           cfg_write,
  input  wire logic [kes_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [kes_pkg::CFG_W-1:0]      cfg_data
);
  import kes_pkg::*;

  // Configuration registers
  logic [DEBOUNCE_W-1:0] debounce_us;
  logic [DETENT_W-1:0]   detent_count;
  logic [UNUSED_W-1:0]   unused_key;
  logic [ID_W-1:0]       switch0_id;
  logic [ID_W-1:0]       switch1_id;
  logic [ID_W-1:0]       encoder0_id;
  logic [ID_W-1:0]       encoder1_id;

  // Poll capture
  logic [STAMP_W-1:0]    now_q;
  logic [SLOT_COUNT-1:0] pressed_q;
  logic [AB_W-1:0]       ab0_q;
  logic [AB_W-1:0]       ab1_q;

  // Sequencer
  scan_state_t           state;
  scan_state_t           state_next;
  logic [SLOT_W-1:0]     scan_cnt;
  logic                  proc_valid;
  logic [SLOT_W-1:0]     proc_slot;
  logic                  poll_accept;
  logic                  out_load;

  // Slot store
  logic                  slot_rd_en;
  logic [SLOT_W-1:0]     slot_rd_addr;
  slot_entry_t           slot_rd_data;
  slot_wr_t              slot_wr;

  // Scan stage
  logic                  cur_level;
  logic [STAMP_W-1:0]    elapsed;
  logic                  settled;
  logic                  is_key;
  logic                  muted;
  logic                  change;
  push_req_t             scan_push;

  // Encoders and queue
  enc_step_t             enc_step;
  push_req_t             enc_push;
  push_req_t             fifo_push;
  logic                  fifo_pop;
  logic                  fifo_empty;
  event_entry_t          fifo_rd;

  assign poll_stall   = (state != ST_IDLE);
  assign poll_accept  = poll_valid && !poll_stall;
  assign slot_rd_addr = VISIT_ORDER[scan_cnt];

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_us  <= DEBOUNCE_RESET;
      detent_count <= DETENT_RESET;
      unused_key   <= UNUSED_RESET;
      switch0_id   <= SWITCH0_RESET;
      switch1_id   <= SWITCH1_RESET;
      encoder0_id  <= ENCODER0_RESET;
      encoder1_id  <= ENCODER1_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_DEBOUNCE: debounce_us  <= cfg_data[DEBOUNCE_W-1:0];
        CFG_DETENT:   detent_count <= cfg_data[DETENT_W-1:0];
        CFG_UNUSED:   unused_key   <= cfg_data[UNUSED_W-1:0];
        CFG_SWITCH0:  switch0_id   <= cfg_data[ID_W-1:0];
        CFG_SWITCH1:  switch1_id   <= cfg_data[ID_W-1:0];
        CFG_ENCODER0: encoder0_id  <= cfg_data[ID_W-1:0];
        CFG_ENCODER1: encoder1_id  <= cfg_data[ID_W-1:0];
        default: ;
      endcase
    end
  end

  // Poll capture
  always_ff @(posedge clk) begin
    if (poll_accept) begin
      now_q     <= now_us;
      pressed_q <= {switch_pressed, key_pressed};
      ab0_q     <= enc0_ab;
      ab1_q     <= enc1_ab;
    end
  end

  // Scan stage: debounce check and write-back of the slot read last cycle
  always_comb begin
    cur_level = pressed_q[proc_slot];
    elapsed   = now_q - slot_rd_data.stamp;
    settled   = elapsed >= STAMP_W'(debounce_us);
    change    = proc_valid && (cur_level != slot_rd_data.level) && settled;
    is_key    = proc_slot < SLOT_W'(KEY_COUNT);
    muted     = is_key && (ID_W'(proc_slot) == ID_W'(unused_key));

    slot_wr.en          = change;
    slot_wr.addr        = proc_slot;
    slot_wr.entry.level = cur_level;
    slot_wr.entry.stamp = now_q;

    scan_push.valid = change && !muted;
    scan_push.kind  = cur_level ? KIND_PRESS : KIND_RELEASE;
    if (is_key) begin
      scan_push.id = ID_W'(proc_slot);
    end else if (proc_slot == SLOT_W'(KEY_COUNT)) begin
      scan_push.id = switch0_id;
    end else begin
      scan_push.id = switch1_id;
    end
  end

  // Queue write source: scan stage and encoders never overlap
  assign fifo_push = scan_push.valid ? scan_push : enc_push;

  // Sequencer state register; the slot counter stops on the last slot
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      scan_cnt   <= '0;
      proc_valid <= 1'b0;
      proc_slot  <= '0;
    end else begin
      state      <= state_next;
      proc_valid <= slot_rd_en;
      proc_slot  <= slot_rd_addr;
      if (state == ST_IDLE) begin
        scan_cnt <= '0;
      end else if (slot_rd_en && (scan_cnt != SLOT_W'(SLOT_COUNT - 1))) begin
        scan_cnt <= scan_cnt + SLOT_W'(1);
      end
    end
  end

  // Sequencer next state and strobes
  always_comb begin
    state_next = state;
    slot_rd_en = 1'b0;
    enc_step   = '0;
    fifo_pop   = 1'b0;
    out_load   = 1'b0;
    case (state)
      ST_IDLE: begin
        if (poll_valid) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        slot_rd_en = 1'b1;
        if (scan_cnt == SLOT_W'(SLOT_COUNT - 1)) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_next = ST_ENC0;
      end
      ST_ENC0: begin
        enc_step.en  = 1'b1;
        enc_step.sel = 1'b0;
        enc_step.ab  = ab0_q;
        state_next   = ST_ENC1;
      end
      ST_ENC1: begin
        enc_step.en  = 1'b1;
        enc_step.sel = 1'b1;
        enc_step.ab  = ab1_q;
        state_next   = ST_POP_RD;
      end
      ST_POP_RD: begin
        if (fifo_empty) begin
          state_next = ST_IDLE;
        end else if (!event_valid || !event_stall) begin
          fifo_pop   = 1'b1;
          state_next = ST_POP_OUT;
        end
      end
      ST_POP_OUT: begin
        out_load   = 1'b1;
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      event_valid <= 1'b0;
    end else if (out_load) begin
      event_valid <= 1'b1;
    end else if (!event_stall) begin
      event_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      event_kind <= fifo_rd.kind;
      event_id   <= fifo_rd.id;
    end
  end

  kes_slot_store u_slot_store (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (slot_rd_en),
    .rd_addr (slot_rd_addr),
    .rd_data (slot_rd_data),
    .wr      (slot_wr)
  );

  kes_encoder u_encoder (
    .clk          (clk),
    .rst          (rst),
    .step         (enc_step),
    .detent_count (detent_count),
    .encoder0_id  (encoder0_id),
    .encoder1_id  (encoder1_id),
    .push         (enc_push)
  );

  kes_event_fifo u_event_fifo (
    .clk     (clk),
    .rst     (rst),
    .push    (fifo_push),
    .pop     (fifo_pop),
    .rd_data (fifo_rd),
    .empty   (fifo_empty)
  );

  // Read and write-back of the slot store never meet on one slot
  a_slot_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(slot_rd_en && slot_wr.en && (slot_rd_addr == slot_wr.addr)))
    else $error("slot store read and write on the same slot");

  // Only one queue write source at a time
  a_single_push: assert property (@(posedge clk) disable iff (rst)
    !(scan_push.valid && enc_push.valid))
    else $error("scan and encoder push in the same cycle");

  // Pop only from a non-empty queue
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    fifo_pop |-> !fifo_empty)
    else $error("pop from empty event queue");

  // A new beat is loaded only into a free output register
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    out_load |-> !event_valid)
    else $error("output beat overwritten");

endmodule
`default_nettype wire
